@@ rtl/core/srd_pkg.sv @@
// Shared types and constants for the scaled rounded divider.
`default_nettype none

package srd_pkg;

    localparam int unsigned DIVIDEND_W = 64;
    localparam int unsigned DIVISOR_W  = 32;
    localparam int unsigned SHIFT_W    = 7;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned STEP_W     = 5;

    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVF = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DBZ = 2'd2;

    localparam logic [DIVISOR_W-1:0] Q_ALL_ONES = '1;
    localparam logic [STEP_W-1:0]    LAST_STEP  = '1;

    typedef struct packed {
        logic load;
        logic shift;
        logic round;
        logic step;
        logic emit;
    } srd_cmd_t;

    typedef struct packed {
        logic decided;
    } srd_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/scaled_rounded_divider.sv @@
// Top level of the scaled rounded 64-by-32 divider.
//
//   Channel   Direction  Handshake            Payload
//   request   in         req_valid/req_stall  dividend, shift_amount, divisor
//   response  out        rsp_valid/rsp_stall  quotient, status
//
// A request runs through the load, shift and round steps, then the restoring
// division loop, one quotient bit per cycle, and the result hand-off before the
// next acceptance. Overflow and divide by zero skip the loop.
// Reset clears the controller and the response valid; payload registers are
// not reset. A stalled response holds and the next request waits in the
// controller's final state only while the response register is occupied and stalled.
`default_nettype none

module scaled_rounded_divider (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire logic [srd_pkg::DIVIDEND_W-1:0]     dividend,
    input  wire logic signed [srd_pkg::SHIFT_W-1:0] shift_amount,
    input  wire logic [srd_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output logic [srd_pkg::DIVISOR_W-1:0]           quotient,
    output logic [srd_pkg::STATUS_W-1:0]            status
);

    srd_pkg::srd_cmd_t cmd;
    srd_pkg::srd_sts_t sts;

    srd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    srd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .dividend     (dividend),
        .shift_amount (shift_amount),
        .divisor      (divisor),
        .quotient     (quotient),
        .status       (status)
    );

endmodule

`default_nettype wire

@@ rtl/core/srd_datapath.sv @@
// Datapath: scaling shift, rounding add, range checks and restoring division.
`default_nettype none

module srd_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire srd_pkg::srd_cmd_t                  cmd,
    output srd_pkg::srd_sts_t                       sts,
    input  wire logic [srd_pkg::DIVIDEND_W-1:0]     dividend,
    input  wire logic signed [srd_pkg::SHIFT_W-1:0] shift_amount,
    input  wire logic [srd_pkg::DIVISOR_W-1:0]      divisor,
    output logic [srd_pkg::DIVISOR_W-1:0]           quotient,
    output logic [srd_pkg::STATUS_W-1:0]            status
);

    logic [srd_pkg::DIVIDEND_W-1:0] num_reg, num_next;
    logic [srd_pkg::DIVISOR_W-1:0]  den_reg;
    logic [srd_pkg::SHIFT_W-1:0]    shamt_reg;
    logic                           decided_reg, decided_next;
    logic [srd_pkg::STATUS_W-1:0]   st_reg, st_next;
    logic [srd_pkg::DIVISOR_W-1:0]  q_out_reg, q_out_next;
    logic [srd_pkg::STATUS_W-1:0]   st_out_reg, st_out_next;

    logic                           is_left;
    logic                           is_right;
    logic [srd_pkg::SHIFT_W-1:0]    right_amt;
    logic [srd_pkg::DIVIDEND_W-1:0] hi_mask;
    logic                           loss;
    logic [srd_pkg::DIVIDEND_W:0]   sum;
    logic [srd_pkg::DIVISOR_W:0]    trial;
    logic                           ge;
    logic [srd_pkg::DIVISOR_W:0]    rem_new;

    always_comb
    begin
        is_left   = (shamt_reg != '0) && !shamt_reg[srd_pkg::SHIFT_W-1];
        is_right  = shamt_reg[srd_pkg::SHIFT_W-1];
        right_amt = -shamt_reg;
        hi_mask   = ~({srd_pkg::DIVIDEND_W{1'b1}} >> shamt_reg);
        loss      = |(num_reg & hi_mask);
        sum       = {1'b0, num_reg} + {{(srd_pkg::DIVIDEND_W - srd_pkg::DIVISOR_W + 2){1'b0}},
                                        den_reg[srd_pkg::DIVISOR_W-1:1]};
        trial     = {num_reg[srd_pkg::DIVIDEND_W-1:srd_pkg::DIVISOR_W],
                     num_reg[srd_pkg::DIVISOR_W-1]};
        ge        = trial >= {1'b0, den_reg};
        rem_new   = ge ? (trial - {1'b0, den_reg}) : trial;

        num_next     = num_reg;
        decided_next = decided_reg;
        st_next      = st_reg;
        q_out_next   = q_out_reg;
        st_out_next  = st_out_reg;

        if (cmd.load)
        begin
            num_next     = dividend;
            decided_next = (divisor == '0);
            st_next      = srd_pkg::ST_DBZ;
        end
        if (cmd.shift && !decided_reg)
        begin
            if (is_left)
            begin
                if (loss)
                begin
                    decided_next = 1'b1;
                    st_next      = srd_pkg::ST_OVF;
                end
                num_next = num_reg << shamt_reg;
            end
            else if (is_right)
            begin
                num_next = num_reg >> right_amt;
            end
        end
        if (cmd.round && !decided_reg)
        begin
            if (sum[srd_pkg::DIVIDEND_W] ||
                (sum[srd_pkg::DIVIDEND_W-1:srd_pkg::DIVISOR_W] >= den_reg))
            begin
                decided_next = 1'b1;
                st_next      = srd_pkg::ST_OVF;
            end
            num_next = sum[srd_pkg::DIVIDEND_W-1:0];
        end
        if (cmd.step)
        begin
            num_next = {rem_new[srd_pkg::DIVISOR_W-1:0],
                        num_reg[srd_pkg::DIVISOR_W-2:0], ge};
        end
        if (cmd.emit)
        begin
            if (decided_reg)
            begin
                q_out_next  = (st_reg == srd_pkg::ST_DBZ) ? '0 : srd_pkg::Q_ALL_ONES;
                st_out_next = st_reg;
            end
            else
            begin
                q_out_next  = num_reg[srd_pkg::DIVISOR_W-1:0];
                st_out_next = srd_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decided_reg <= 1'b0;
        end
        else
        begin
            decided_reg <= decided_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        st_reg     <= st_next;
        q_out_reg  <= q_out_next;
        st_out_reg <= st_out_next;
        if (cmd.load)
        begin
            den_reg   <= divisor;
            shamt_reg <= shift_amount;
        end
    end

    assign sts.decided = decided_reg;
    assign quotient    = q_out_reg;
    assign status      = st_out_reg;

endmodule

`default_nettype wire

@@ rtl/core/srd_ctrl.sv @@
// Controller: sequences load, shift, round, division steps and result hand-off.
`default_nettype none

module srd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output srd_pkg::srd_cmd_t      cmd,
    input  wire srd_pkg::srd_sts_t sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [srd_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic                        slot_free;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        slot_free      = !rsp_valid_reg || !rsp_stall;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.decided)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == srd_pkg::LAST_STEP)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/srd_checker.sv @@
// Port-level checks for the scaled rounded divider, bound to the top level.
`default_nettype none

module srd_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               req_valid,
    input wire logic                               req_stall,
    input wire logic                               rsp_valid,
    input wire logic                               rsp_stall,
    input wire logic [srd_pkg::DIVISOR_W-1:0]      quotient,
    input wire logic [srd_pkg::STATUS_W-1:0]       status
);

    logic req_fire;

    assign req_fire = req_valid && !req_stall;

    // A stalled response keeps its valid and its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(quotient) && $stable(status))
        else $error("response changed while stalled");

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> req_stall)
        else $error("request accepted while another is in flight");

    // Divide by zero always reports a zero quotient.
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == srd_pkg::ST_DBZ) |-> (quotient == '0))
        else $error("divide by zero with nonzero quotient");

    // Overflow always reports an all-ones quotient.
    a_ovf_ones: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == srd_pkg::ST_OVF) |-> (quotient == srd_pkg::Q_ALL_ONES))
        else $error("overflow without all-ones quotient");

    // Every response carries a defined status code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == srd_pkg::ST_OK) || (status == srd_pkg::ST_OVF) ||
                      (status == srd_pkg::ST_DBZ))
        else $error("undefined status code");

endmodule

bind scaled_rounded_divider srd_checker u_srd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .quotient     (quotient),
    .status       (status)
);

`default_nettype wire
